FILE: sv/two_pass_stats_histogram_defines.svh
// assertion macros of the two-pass statistics engine, used by its sequencing state machine
`ifndef TWO_PASS_STATS_HISTOGRAM_DEFINES_SVH
`define TWO_PASS_STATS_HISTOGRAM_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define TPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tps check failed");
// next-cycle implication, disabled in reset
`define TPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tps check failed");
`else
`define TPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/tps_pkg.sv
// types, codes and helpers of the two-pass statistics engine
package tps_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 48;
    localparam int SQ_W     = 62;
    localparam int DEV_W    = 64;
    localparam int NB_W     = 9;
    localparam int BI_W     = 8;
    localparam int OP_W     = 3;
    localparam int SPAN_W   = 17;
    localparam int NUM_W    = 26;
    localparam int DIV_W    = 64;
    localparam int DVS_W    = 32;
    localparam int ITER_W   = 7;
    localparam int MAG_W    = 49;

    localparam logic [CNT_W-1:0]        CNT_MAX = '1;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SQ_W-1:0]         SQ_MAX  = '1;
    localparam logic [DEV_W-1:0]        DEV_MAX = '1;
    localparam logic [ITER_W-1:0]       ITERS_FULL = 7'd64;
    localparam logic [ITER_W-1:0]       ITERS_HALF = 7'd32;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE  = 3'd0,
        OP_RESTART = 3'd1,
        OP_PASS2   = 3'd2,
        OP_READ    = 3'd3,
        OP_FORCE   = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_P1_ACC,
        S_P2_MUL,
        S_P2_ACC,
        S_BIN_DIV,
        S_DIV_MEAN,
        S_DIV_MSQ,
        S_CLEAR,
        S_RD,
        S_RD_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_MSQ,
        DIV_BIN
    } t_div_sel;

    typedef enum logic [2:0] {
        CLS_UNDER,
        CLS_OVER,
        CLS_LAST,
        CLS_ZERO,
        CLS_DIV
    } t_cls;

    typedef struct packed {
        logic     load_in;
        logic     p1_mul;
        logic     p1_acc;
        logic     p2_prep;
        logic     p2_mul;
        logic     p2_acc;
        logic     div_start;
        t_div_sel div_sel;
        logic     span_latch;
        logic     zero_stats;
        logic     mean_latch;
        logic     msq_latch;
        logic     clear_all;
        logic     clear_second;
        logic     sweep_step;
        logic     addr_load;
        logic     mem_rd;
        logic     cell_inc;
        logic     bc_mem;
        logic     bc_above;
        logic     force_bounds;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pass;
        logic            count_zero;
        logic            bin_ok;
        t_cls            cls;
        logic            sweep_last;
        logic            div_done;
    } t_stat;

    function automatic logic [CNT_W-1:0] inc32(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

FILE: sv/tps_div.sv
// iterative restoring divider, one quotient bit per cycle
module tps_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tps_pkg::DIV_W-1:0]  i_dividend,
    input  logic [tps_pkg::DVS_W-1:0]  i_divisor,
    input  logic [tps_pkg::ITER_W-1:0] i_iters,
    output logic [tps_pkg::DIV_W-1:0]  o_quotient,
    output logic                       o_done
);
    import tps_pkg::*;

    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [ITER_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;
    logic              fits;

    assign rem_sh  = {r_rem, r_quo[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign fits    = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= i_iters;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == ITER_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

FILE: sv/tps_datapath.sv
// statistics registers, histogram memory and arithmetic
module tps_datapath #(
    parameter int BINS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tps_pkg::t_cmd                     i_cmd,
    output tps_pkg::t_stat                    o_stat,
    input  logic [tps_pkg::NB_W-1:0]          i_active_bins,
    input  logic [tps_pkg::OP_W-1:0]          i_operation,
    input  logic signed [tps_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic signed [tps_pkg::SAMPLE_W-1:0] i_upper_value,
    input  logic [tps_pkg::BI_W-1:0]          i_bin_index,
    output logic                              o_phase,
    output logic [tps_pkg::CNT_W-1:0]         o_sample_count,
    output logic signed [tps_pkg::SUM_W-1:0]  o_first_sum,
    output logic [tps_pkg::SQ_W-1:0]          o_square_sum,
    output logic signed [tps_pkg::SAMPLE_W-1:0] o_minimum,
    output logic signed [tps_pkg::SAMPLE_W-1:0] o_maximum,
    output logic [tps_pkg::DEV_W-1:0]         o_deviation_sum,
    output logic [tps_pkg::CNT_W-1:0]         o_under_count,
    output logic [tps_pkg::CNT_W-1:0]         o_over_count,
    output logic [tps_pkg::CNT_W-1:0]         o_bin_count
);
    import tps_pkg::*;

    localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;

    // latched transaction
    logic [OP_W-1:0]            r_op;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_up;
    logic [BI_W-1:0]            r_bi;

    // statistics state
    logic                       r_pass;
    logic [CNT_W-1:0]           r_count;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SQ_W-1:0]            r_sq;
    logic signed [SAMPLE_W-1:0] r_lo;
    logic signed [SAMPLE_W-1:0] r_hi;
    logic signed [SPAN_W-1:0]   r_span;
    logic [DEV_W-1:0]           r_dev;
    logic [CNT_W-1:0]           r_below;
    logic [CNT_W-1:0]           r_above;
    logic [CNT_W-1:0]           r_bc;
    logic [AW-1:0]              r_sweep;

    // intermediate stages
    logic [CNT_W-1:0]           r_p1_sq;
    logic [MAG_W-1:0]           r_mag;
    logic [SPAN_W-1:0]          r_rel;
    t_cls                       r_cls;
    logic [DEV_W-1:0]           r_dsq;
    logic [NUM_W-1:0]           r_num;
    logic [AW-1:0]              r_addr;
    logic [CNT_W-1:0]           r_rd;

    // histogram memory
    logic [CNT_W-1:0]           r_mem [BINS];

    logic [NB_W-1:0]            nb;
    logic signed [CNT_W-1:0]    p1_sq_c;
    logic signed [SUM_W:0]      sum_n;
    logic [SQ_W:0]              sq_n;
    logic signed [MAG_W-1:0]    dev_d;
    logic [DEV_W-1:0]           dsq_c;
    logic [NUM_W-1:0]           num_c;
    logic [DEV_W:0]             dev_n;
    t_cls                       cls_c;
    logic [SUM_W-1:0]           sum_mag;
    logic [DIV_W-1:0]           div_quo;
    logic                       div_done;
    logic [DIV_W-1:0]           div_dividend;
    logic [DVS_W-1:0]           div_divisor;
    logic [ITER_W-1:0]          div_iters;
    logic [NB_W-1:0]            idx_c;
    logic [AW-1:0]              addr_c;
    logic                       sweep_last;
    logic                       mem_we;
    logic [AW-1:0]              mem_wa;
    logic [CNT_W-1:0]           mem_wd;

    // cells in use: zero acts as one, clipped to the memory depth
    always_comb begin
        if (i_active_bins == '0) begin
            nb = NB_W'(1);
        end else if (32'(i_active_bins) > BINS) begin
            nb = NB_W'(BINS);
        end else begin
            nb = i_active_bins;
        end
    end

    assign p1_sq_c = r_x * r_x;
    assign sum_n   = (SUM_W+1)'(r_sum) + (SUM_W+1)'(r_x);
    assign sq_n    = (SQ_W+1)'(r_sq) + (SQ_W+1)'(r_p1_sq);
    assign dev_d   = MAG_W'($signed({r_x, 8'h00})) - MAG_W'(r_sum);
    assign dsq_c   = r_mag[31:0] * r_mag[31:0];
    assign num_c   = r_rel * nb;
    assign dev_n   = (DEV_W+1)'(r_dev) + (DEV_W+1)'(r_dsq);
    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    always_comb begin
        if (r_x < r_lo) begin
            cls_c = CLS_UNDER;
        end else if (r_x > r_hi) begin
            cls_c = CLS_OVER;
        end else if (r_x == r_hi) begin
            cls_c = CLS_LAST;
        end else if (r_span > SPAN_W'(0)) begin
            cls_c = CLS_DIV;
        end else begin
            cls_c = CLS_ZERO;
        end
    end

    // divider operand selection
    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_MSQ: begin
                div_dividend = {2'b00, r_sq};
                div_divisor  = r_count;
                div_iters    = ITERS_FULL;
            end
            DIV_BIN: begin
                div_dividend = {6'b0, r_num, 32'b0};
                div_divisor  = DVS_W'(unsigned'(r_span));
                div_iters    = ITERS_HALF;
            end
            default: begin
                div_dividend = {8'b0, sum_mag, 8'b0};
                div_divisor  = r_count;
                div_iters    = ITERS_FULL;
            end
        endcase
    end

    tps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_iters    (div_iters),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    assign idx_c = (div_quo >= DIV_W'(nb)) ? nb - 1'b1 : div_quo[NB_W-1:0];

    always_comb begin
        if (r_op == OP_READ) begin
            addr_c = AW'(r_bi);
        end else begin
            unique case (r_cls)
                CLS_LAST: addr_c = AW'(nb - 1'b1);
                CLS_DIV:  addr_c = AW'(idx_c);
                default:  addr_c = '0;
            endcase
        end
    end

    assign sweep_last = (32'(r_sweep) == BINS - 1);

    // payload and pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op <= i_operation;
            r_x  <= i_sample_value;
            r_up <= i_upper_value;
            r_bi <= i_bin_index;
        end
        if (i_cmd.p1_mul) begin
            r_p1_sq <= unsigned'(p1_sq_c);
        end
        if (i_cmd.p2_prep) begin
            r_mag <= dev_d[MAG_W-1] ? unsigned'(-dev_d) : unsigned'(dev_d);
            r_rel <= SPAN_W'(r_x) - SPAN_W'(r_lo);
            r_cls <= cls_c;
        end
        if (i_cmd.p2_mul) begin
            r_dsq <= (|r_mag[MAG_W-1:32]) ? DEV_MAX : dsq_c;
            r_num <= num_c;
        end
        if (i_cmd.addr_load) begin
            r_addr <= addr_c;
        end
    end

    // statistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass  <= 1'b0;
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
            r_span  <= '0;
            r_dev   <= '0;
            r_below <= '0;
            r_above <= '0;
            r_bc    <= '0;
            r_sweep <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_bc <= '0;
            end
            if (i_cmd.p1_acc) begin
                r_count <= inc32(r_count);
                if (sum_n[SUM_W] != sum_n[SUM_W-1]) begin
                    r_sum <= sum_n[SUM_W] ? SUM_MIN : SUM_MAX;
                end else begin
                    r_sum <= sum_n[SUM_W-1:0];
                end
                r_sq <= sq_n[SQ_W] ? SQ_MAX : sq_n[SQ_W-1:0];
                if (r_x < r_lo) begin
                    r_lo <= r_x;
                end
                if (r_x > r_hi) begin
                    r_hi <= r_x;
                end
            end
            if (i_cmd.p2_acc) begin
                r_count <= inc32(r_count);
                r_dev   <= dev_n[DEV_W] ? DEV_MAX : dev_n[DEV_W-1:0];
                if (r_cls == CLS_UNDER) begin
                    r_below <= inc32(r_below);
                end
                if (r_cls == CLS_OVER) begin
                    r_above <= inc32(r_above);
                end
            end
            if (i_cmd.span_latch) begin
                r_span <= SPAN_W'(r_hi) - SPAN_W'(r_lo);
            end
            if (i_cmd.zero_stats) begin
                r_sum <= '0;
                r_sq  <= '0;
            end
            if (i_cmd.mean_latch) begin
                r_sum <= r_sum[SUM_W-1] ? -signed'(div_quo[SUM_W-1:0])
                                        : signed'(div_quo[SUM_W-1:0]);
            end
            if (i_cmd.msq_latch) begin
                r_sq <= div_quo[SQ_W-1:0];
            end
            if (i_cmd.force_bounds) begin
                r_lo <= r_x;
                r_hi <= r_up;
            end
            if (i_cmd.clear_second) begin
                r_pass  <= 1'b1;
                r_count <= '0;
                r_dev   <= '0;
                r_below <= '0;
                r_above <= '0;
            end
            if (i_cmd.clear_all) begin
                r_pass  <= 1'b0;
                r_count <= '0;
                r_sum   <= '0;
                r_sq    <= '0;
                r_lo    <= '0;
                r_hi    <= '0;
                r_span  <= '0;
                r_dev   <= '0;
                r_below <= '0;
                r_above <= '0;
            end
            if (i_cmd.sweep_step) begin
                r_sweep <= sweep_last ? '0 : r_sweep + 1'b1;
            end
            if (i_cmd.bc_mem) begin
                r_bc <= r_rd;
            end
            if (i_cmd.bc_above) begin
                r_bc <= r_above;
            end
        end
    end

    // histogram memory: one write port, one registered read port
    assign mem_we = i_cmd.sweep_step | i_cmd.cell_inc;
    assign mem_wa = i_cmd.sweep_step ? r_sweep : r_addr;
    assign mem_wd = i_cmd.sweep_step ? '0 : inc32(r_rd);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[r_addr];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_phase         <= r_pass;
            o_sample_count  <= r_count;
            o_first_sum     <= r_sum;
            o_square_sum    <= r_sq;
            o_minimum       <= r_lo;
            o_maximum       <= r_hi;
            o_deviation_sum <= r_dev;
            o_under_count   <= r_below;
            o_over_count    <= r_above;
            o_bin_count     <= r_bc;
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.pass       = r_pass;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.bin_ok     = ({1'b0, r_bi} < nb);
    assign o_stat.cls        = r_cls;
    assign o_stat.sweep_last = sweep_last;
    assign o_stat.div_done   = div_done;

endmodule

FILE: sv/tps_ctrl.sv
// sequencing state machine of the two-pass statistics engine
`include "two_pass_stats_histogram_defines.svh"
module tps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output tps_pkg::t_cmd   o_cmd,
    input  tps_pkg::t_stat  i_stat
);
    import tps_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        cmd         = '0;
        cmd.div_sel = DIV_MEAN;
        n_state     = r_state;
        unique case (r_state)
            S_INIT: begin
                cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (t_op'(i_stat.op))
                    OP_SAMPLE: begin
                        if (i_stat.pass) begin
                            cmd.p2_prep = 1'b1;
                            n_state     = S_P2_MUL;
                        end else begin
                            cmd.p1_mul = 1'b1;
                            n_state    = S_P1_ACC;
                        end
                    end
                    OP_RESTART: begin
                        cmd.clear_all = 1'b1;
                        n_state       = S_CLEAR;
                    end
                    OP_PASS2: begin
                        priority if (!i_stat.pass && !i_stat.count_zero) begin
                            cmd.span_latch = 1'b1;
                            cmd.div_start  = 1'b1;
                            cmd.div_sel    = DIV_MEAN;
                            n_state        = S_DIV_MEAN;
                        end else if (!i_stat.pass) begin
                            cmd.span_latch   = 1'b1;
                            cmd.zero_stats   = 1'b1;
                            cmd.clear_second = 1'b1;
                            n_state          = S_CLEAR;
                        end else begin
                            cmd.clear_second = 1'b1;
                            n_state          = S_CLEAR;
                        end
                    end
                    OP_READ: begin
                        if (i_stat.bin_ok) begin
                            cmd.addr_load = 1'b1;
                            n_state       = S_RD;
                        end else begin
                            cmd.bc_above = 1'b1;
                            n_state      = S_DONE;
                        end
                    end
                    OP_FORCE: begin
                        cmd.force_bounds = !i_stat.pass;
                        n_state          = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_P1_ACC: begin
                cmd.p1_acc = 1'b1;
                n_state    = S_DONE;
            end
            S_P2_MUL: begin
                cmd.p2_mul = 1'b1;
                n_state    = S_P2_ACC;
            end
            S_P2_ACC: begin
                cmd.p2_acc = 1'b1;
                unique case (i_stat.cls)
                    CLS_UNDER, CLS_OVER: begin
                        n_state = S_DONE;
                    end
                    CLS_DIV: begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_BIN;
                        n_state       = S_BIN_DIV;
                    end
                    default: begin
                        cmd.addr_load = 1'b1;
                        n_state       = S_RD;
                    end
                endcase
            end
            S_BIN_DIV: begin
                cmd.div_sel = DIV_BIN;
                if (i_stat.div_done) begin
                    cmd.addr_load = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_DIV_MEAN: begin
                if (i_stat.div_done) begin
                    cmd.mean_latch = 1'b1;
                    cmd.div_start  = 1'b1;
                    cmd.div_sel    = DIV_MSQ;
                    n_state        = S_DIV_MSQ;
                end
            end
            S_DIV_MSQ: begin
                cmd.div_sel = DIV_MSQ;
                if (i_stat.div_done) begin
                    cmd.msq_latch    = 1'b1;
                    cmd.clear_second = 1'b1;
                    n_state          = S_CLEAR;
                end
            end
            S_CLEAR: begin
                cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                cmd.mem_rd = 1'b1;
                n_state    = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                if (t_op'(i_stat.op) == OP_READ) begin
                    cmd.bc_mem = 1'b1;
                end else begin
                    cmd.cell_inc = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `TPS_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, r_state == S_IDLE && i_in_valid, r_state == S_DECODE)
    `TPS_ASSERT_NEXT(a_div_start_clears_done, i_clk, i_rst_n, cmd.div_start, !i_stat.div_done)
    `TPS_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, cmd.out_load, !r_out_valid || i_out_ready)

endmodule

FILE: sv/two_pass_stats_histogram.sv
// top level of the two-pass statistics and histogram engine
//
//  channel   handshake                    payload
//  -------   ---------------------------  -------------------------------------------
//  input     i_valid / o_ready            i_operation, i_sample_value, i_upper_value,
//                                         i_bin_index
//  output    o_valid / i_ready            o_phase ... o_bin_count (ten fields)
//  config    psel, penable, pwrite, pready  paddr, pwdata, prdata (active bins)
//
// a pass-one sample is squared and accumulated; a binned pass-two sample also runs the
// 32-step divider that computes the cell index, plus a memory read-modify-write
// entering pass two from pass one runs two 64-step divisions (mean, mean square)
// and then clears the histogram, one cell per cycle
// restart and a repeated pass-two entry run only the clearing sweep
// after reset the histogram is cleared before o_ready rises
// a transaction is taken while a previous result still waits in the output register
module two_pass_stats_histogram #(
    parameter int BINS = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [tps_pkg::OP_W-1:0]              i_operation,
    input  logic signed [tps_pkg::SAMPLE_W-1:0]   i_sample_value,
    input  logic signed [tps_pkg::SAMPLE_W-1:0]   i_upper_value,
    input  logic [tps_pkg::BI_W-1:0]              i_bin_index,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_phase,
    output logic [tps_pkg::CNT_W-1:0]             o_sample_count,
    output logic signed [tps_pkg::SUM_W-1:0]      o_first_sum,
    output logic [tps_pkg::SQ_W-1:0]              o_square_sum,
    output logic signed [tps_pkg::SAMPLE_W-1:0]   o_minimum,
    output logic signed [tps_pkg::SAMPLE_W-1:0]   o_maximum,
    output logic [tps_pkg::DEV_W-1:0]             o_deviation_sum,
    output logic [tps_pkg::CNT_W-1:0]             o_under_count,
    output logic [tps_pkg::CNT_W-1:0]             o_over_count,
    output logic [tps_pkg::CNT_W-1:0]             o_bin_count,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [1:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import tps_pkg::*;

    logic [NB_W-1:0] r_active_bins;
    t_cmd            cmd;
    t_stat           stat;

    // single register at word 0, so the address bits select nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_bins <= NB_W'(256);
        end else if (psel && penable && pwrite) begin
            r_active_bins <= pwdata[NB_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'b00) ? 32'(r_active_bins) : 32'(r_active_bins);

    // sequencing
    tps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // registers, memory, divider and result register
    tps_datapath #(
        .BINS (BINS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_active_bins   (r_active_bins),
        .i_operation     (i_operation),
        .i_sample_value  (i_sample_value),
        .i_upper_value   (i_upper_value),
        .i_bin_index     (i_bin_index),
        .o_phase         (o_phase),
        .o_sample_count  (o_sample_count),
        .o_first_sum     (o_first_sum),
        .o_square_sum    (o_square_sum),
        .o_minimum       (o_minimum),
        .o_maximum       (o_maximum),
        .o_deviation_sum (o_deviation_sum),
        .o_under_count   (o_under_count),
        .o_over_count    (o_over_count),
        .o_bin_count     (o_bin_count)
    );

endmodule

FILE: dv/tb_top.sv
// testbench for the two-pass statistics and histogram engine
`timescale 1ns / 1ps

module tb_top;
    import tps_pkg::*;

    localparam int ITEM_TARGET  = 1050;
    localparam int CYCLE_LIMIT  = 3000000;
    // a pass-two entry runs two 64-step divisions plus a sweep over all BINS cells
    localparam int DRAIN_CYCLES = 600;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [1:0] REG_ACTIVE_BINS = 2'd0;
    // operation codes left undefined by the package
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic              phase;
        logic [CNT_W-1:0]  sample_count;
        logic [SUM_W-1:0]  first_sum;
        logic [SQ_W-1:0]   square_sum;
        logic [15:0]       minimum;
        logic [15:0]       maximum;
        logic [DEV_W-1:0]  deviation_sum;
        logic [CNT_W-1:0]  under_count;
        logic [CNT_W-1:0]  over_count;
        logic [CNT_W-1:0]  bin_count;
    } t_stats_snapshot;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [OP_W-1:0] i_operation = '0;
    logic signed [15:0] i_sample_value = '0;
    logic signed [15:0] i_upper_value = '0;
    logic [BI_W-1:0] i_bin_index = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_phase;
    logic [CNT_W-1:0] o_sample_count;
    logic signed [SUM_W-1:0] o_first_sum;
    logic [SQ_W-1:0] o_square_sum;
    logic signed [15:0] o_minimum;
    logic signed [15:0] o_maximum;
    logic [DEV_W-1:0] o_deviation_sum;
    logic [CNT_W-1:0] o_under_count;
    logic [CNT_W-1:0] o_over_count;
    logic [CNT_W-1:0] o_bin_count;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    two_pass_stats_histogram dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_sample_value(i_sample_value),
        .i_upper_value(i_upper_value), .i_bin_index(i_bin_index),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_phase(o_phase), .o_sample_count(o_sample_count),
        .o_first_sum(o_first_sum), .o_square_sum(o_square_sum),
        .o_minimum(o_minimum), .o_maximum(o_maximum),
        .o_deviation_sum(o_deviation_sum), .o_under_count(o_under_count),
        .o_over_count(o_over_count), .o_bin_count(o_bin_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // predictor state, mirrors the engine after every transaction
    // ---------------------------------------------------------------
    logic [8:0]        bins_reg = 9'd256;
    logic              pass_two;
    logic [CNT_W-1:0]  n_samples;
    longint            sum_mean;      // running sum, later the Q.8 mean
    logic [63:0]       sq_meansq;     // sum of squares, later the mean square
    int                lo_bound;
    int                hi_bound;
    int                span;
    logic [DEV_W-1:0]  dev_acc;
    logic [CNT_W-1:0]  n_under;
    logic [CNT_W-1:0]  n_over;
    logic [CNT_W-1:0]  cells [0:255];

    t_stats_snapshot expected_results [$];
    int mismatches = 0;
    int items_sent = 0;
    int cycles = 0;
    int rx_stall = 0;
    int rx_hold = 0;
    bit no_idle = 1'b0;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic int bins_used();
        if (bins_reg == 0) return 1;
        if (bins_reg > 256) return 256;
        return int'(bins_reg);
    endfunction

    function automatic void clear_stats();
        pass_two = 1'b0;
        n_samples = '0;
        sum_mean = 0;
        sq_meansq = '0;
        lo_bound = 0;
        hi_bound = 0;
        span = 0;
        dev_acc = '0;
        n_under = '0;
        n_over = '0;
        foreach (cells[i]) cells[i] = '0;
    endfunction

    function automatic void enter_pass_two();
        longint mag;
        if (!pass_two) begin
            if (n_samples != 0) begin
                mag = (sum_mean < 0) ? -sum_mean : sum_mean;
                mag = (mag * 256) / longint'(n_samples);
                sum_mean = (sum_mean < 0) ? -mag : mag;
                sq_meansq = sq_meansq / {32'd0, n_samples};
            end else begin
                sum_mean = 0;
                sq_meansq = '0;
            end
            span = hi_bound - lo_bound;
        end
        pass_two = 1'b1;
        n_samples = '0;
        dev_acc = '0;
        n_under = '0;
        n_over = '0;
        foreach (cells[i]) cells[i] = '0;
    endfunction

    function automatic void accumulate_first(input int x);
        longint sq;
        sq = longint'(x) * longint'(x);
        n_samples = sat_inc(n_samples);
        sum_mean += x;
        if (sum_mean > 64'sh7FFF_FFFF_FFFF) sum_mean = 64'sh7FFF_FFFF_FFFF;
        if (sum_mean < -64'sh8000_0000_0000) sum_mean = -64'sh8000_0000_0000;
        sq_meansq += sq;
        if (sq_meansq > 64'h3FFF_FFFF_FFFF_FFFF) sq_meansq = 64'h3FFF_FFFF_FFFF_FFFF;
        if (x < lo_bound) lo_bound = x;
        if (x > hi_bound) hi_bound = x;
    endfunction

    function automatic void bin_second(input int x);
        longint d;
        longint mag;
        logic [63:0] sq;
        logic [64:0] total;
        longint idx;
        int nb;
        nb = bins_used();
        d = longint'(x) * 256 - sum_mean;
        mag = (d < 0) ? -d : d;
        sq = (mag >= 64'sh1_0000_0000) ? '1 : 64'(mag * mag);
        n_samples = sat_inc(n_samples);
        total = {1'b0, dev_acc} + {1'b0, sq};
        dev_acc = total[64] ? '1 : total[63:0];
        if (x < lo_bound) begin
            n_under = sat_inc(n_under);
        end else if (x > hi_bound) begin
            n_over = sat_inc(n_over);
        end else begin
            if (x == hi_bound) idx = nb - 1;
            else if (span > 0) idx = (longint'(x - lo_bound) * nb) / span;
            else idx = 0;
            if (idx >= nb) idx = nb - 1;
            cells[idx] = sat_inc(cells[idx]);
        end
    endfunction

    function automatic t_stats_snapshot predict_stats(input logic [OP_W-1:0] op,
            input int x, input int up, input logic [BI_W-1:0] bi);
        t_stats_snapshot r;
        logic [CNT_W-1:0] bc;
        bc = '0;
        case (op)
            OP_SAMPLE: begin
                if (pass_two) bin_second(x);
                else accumulate_first(x);
            end
            OP_RESTART: clear_stats();
            OP_PASS2: enter_pass_two();
            OP_READ: bc = (int'(bi) >= bins_used()) ? n_over : cells[bi];
            OP_FORCE: begin
                if (!pass_two) begin
                    lo_bound = x;
                    hi_bound = up;
                end
            end
            default: ;
        endcase
        r.phase = pass_two;
        r.sample_count = n_samples;
        r.first_sum = sum_mean[SUM_W-1:0];
        r.square_sum = sq_meansq[SQ_W-1:0];
        r.minimum = lo_bound[15:0];
        r.maximum = hi_bound[15:0];
        r.deviation_sum = dev_acc;
        r.under_count = n_under;
        r.over_count = n_over;
        r.bin_count = bc;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------
    // caller stands at a falling edge; returns at a falling edge
    task automatic send_op(input logic [OP_W-1:0] op, input int x, input int up,
            input int bi);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation = op;
        i_sample_value = x[15:0];
        i_upper_value = up[15:0];
        i_bin_index = bi[7:0];
        i_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        // the block sees only the low 16 bits of each value
        expected_results.push_back(predict_stats(op, int'($signed(x[15:0])),
                                                 int'($signed(up[15:0])), bi[7:0]));
        items_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // setup and access phase, then a read back of the same register
    task automatic write_bins(input logic [8:0] value);
        wait_idle();
        psel = 1'b1; pwrite = 1'b1; paddr = REG_ACTIVE_BINS; pwdata = {23'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable = 1'b0; pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[8:0] !== value) begin
            mismatches++;
            if (mismatches <= 10)
                $display("active bins read back %0d, expected %0d", prdata[8:0], value);
        end
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0;
        bins_reg = value;
    endtask

    function automatic int pick_sample();
        case ($urandom_range(0, 4))
            0: return $signed(16'($urandom));
            1: return $urandom_range(0, 255) - 128;
            2: return $urandom_range(0, 1) ? 32767 : -32768;
            default: return ($urandom_range(0, 1) ? hi_bound : lo_bound)
                            + $urandom_range(0, 6) - 3;
        endcase
    endfunction

    function automatic int clip16(input int v);
        return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    function automatic logic [8:0] pick_bins();
        case ($urandom_range(0, 9))
            0: return 9'd1;
            1: return 9'd256;
            2: return 9'd0;
            3: return 9'd511;
            4: return 9'd2;
            5: return 9'd255;
            default: return 9'($urandom_range(1, 511));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // result side: stall draw per transaction plus optional long hold
    // ---------------------------------------------------------------
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_ready = 1'b0;
                rx_hold--;
            end else if (rx_stall > 0) begin
                i_ready = 1'b0;
                rx_stall--;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
            input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%s mismatch: expected %h, got %h", name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_stats_snapshot e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("two_pass_stats_histogram test failed");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            rx_stall = no_idle ? 0 : $urandom_range(0, 7);
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result transaction with none expected");
            end else begin
                e = expected_results.pop_front();
                check_field("phase", 64'(e.phase), 64'(o_phase));
                check_field("sample_count", 64'(e.sample_count), 64'(o_sample_count));
                check_field("first_sum", 64'(e.first_sum), 64'(unsigned'(o_first_sum)));
                check_field("square_sum", 64'(e.square_sum), 64'(o_square_sum));
                check_field("minimum", 64'(e.minimum), 64'(unsigned'(o_minimum)));
                check_field("maximum", 64'(e.maximum), 64'(unsigned'(o_maximum)));
                check_field("deviation_sum", e.deviation_sum, o_deviation_sum);
                check_field("under_count", 64'(e.under_count), 64'(o_under_count));
                check_field("over_count", 64'(e.over_count), 64'(o_over_count));
                check_field("bin_count", 64'(e.bin_count), 64'(o_bin_count));
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    // extremes, every operation and the corner cases of binning
    task automatic test_directed();
        send_op(OP_READ, 0, 0, 0);
        send_op(OP_FORCE, -32768, 32767, 0);
        send_op(OP_SAMPLE, -32768, 0, 0);
        send_op(OP_SAMPLE, 32767, 0, 0);
        send_op(OP_SAMPLE, 0, 0, 0);
        send_op(OP_PASS2, 0, 0, 0);
        send_op(OP_SAMPLE, -32768, 0, 0);
        send_op(OP_SAMPLE, 32767, 0, 0);         // equal to max, last cell
        send_op(OP_SAMPLE, 0, 0, 0);
        send_op(OP_READ, 0, 0, 0);
        send_op(OP_READ, 0, 0, 255);
        send_op(OP_UNUSED_LAST, 1, 2, 3);
        send_op(OP_FORCE, 5, 4, 0);              // ignored in pass two
        send_op(OP_PASS2, 0, 0, 0);              // clears pass-two counts only
        send_op(OP_RESTART, 0, 0, 0);
        send_op(OP_PASS2, 0, 0, 0);              // empty pass one, mean of zero
        send_op(OP_SAMPLE, 0, 0, 0);             // zero span
        send_op(OP_SAMPLE, -1, 0, 0);
        send_op(OP_SAMPLE, 1, 0, 0);
        send_op(OP_RESTART, 0, 0, 0);
        send_op(OP_FORCE, 100, -100, 0);         // min above max
        send_op(OP_SAMPLE, 7, 0, 0);
        send_op(OP_PASS2, 0, 0, 0);
        send_op(OP_SAMPLE, 0, 0, 0);
        send_op(OP_READ, 0, 0, 200);
        write_bins(9'd4);
        send_op(OP_READ, 0, 0, 4);               // beyond active cells
    endtask

    // a well-formed pass one / pass two sequence with random content
    task automatic run_two_pass_sequence();
        int n1;
        int n2;
        int a;
        int b;
        send_op(OP_RESTART, 0, 0, 0);
        if ($urandom_range(0, 2) != 0) begin
            a = pick_sample();
            b = ($urandom_range(0, 4) == 0) ? a : pick_sample();
            if ($urandom_range(0, 5) != 0 && a > b) send_op(OP_FORCE, b, a, 0);
            else send_op(OP_FORCE, a, b, 0);
        end
        n1 = $urandom_range(1, 16);
        repeat (n1) send_op(OP_SAMPLE, pick_sample(), 0, 0);
        send_op(OP_PASS2, 0, 0, 0);
        n2 = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
        repeat (n2) begin
            if ($urandom_range(0, 6) == 0)
                send_op(OP_READ, 0, 0, $urandom_range(0, 255));
            else
                send_op(OP_SAMPLE, clip16(pick_sample()), 0, 0);
        end
        repeat ($urandom_range(1, 4))
            send_op(OP_READ, 0, 0, ($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 255)));
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_op(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                       $signed(16'($urandom)), $signed(16'($urandom)), $urandom_range(0, 255));
            1: send_op(OP_PASS2, 0, 0, 0);
            2: send_op(OP_FORCE, $signed(16'($urandom)), $signed(16'($urandom)), 0);
            default: send_op(OP_SAMPLE, $signed(16'($urandom)), 0, 0);
        endcase
    endtask

    task automatic test_random();
        int seq_no;
        seq_no = 0;
        while (items_sent < ITEM_TARGET) begin
            if (seq_no % 6 == 0) write_bins(pick_bins());
            no_idle = (seq_no % 9 == 4);
            if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) send_noise();
            else run_two_pass_sequence();
            seq_no++;
        end
        no_idle = 1'b0;
    endtask

    // output held off long enough for the block to back up into its input
    task automatic test_backpressure();
        wait_idle();
        rx_hold = 400;
        no_idle = 1'b1;
        send_op(OP_RESTART, 0, 0, 0);
        repeat (20) send_op(OP_SAMPLE, pick_sample(), 0, 0);
        send_op(OP_PASS2, 0, 0, 0);
        repeat (6) send_op(OP_SAMPLE, pick_sample(), 0, 0);
        no_idle = 1'b0;
    endtask

    initial begin
        clear_stats();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        write_bins(9'd256);
        test_backpressure();
        test_random();
        write_bins(9'd1);
        run_two_pass_sequence();
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("two_pass_stats_histogram test passed");
        end else begin
            $display("two_pass_stats_histogram test failed");
        end
        $finish;
    end
endmodule
